### src/dense_prim_mst_assert.svh
// assertion macros shared by the dense prim mst checker
`ifndef DENSE_PRIM_MST_ASSERT_SVH
`define DENSE_PRIM_MST_ASSERT_SVH

// clocked assertion, off while reset is high
`define DPM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// clocked assertion that also holds across reset
`define DPM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

### src/dpm_pkg.sv
// shared types, constants and state codes of the dense prim mst block
package dpm_pkg;

   localparam int DEF_MAX_VERTICES = 32;
   localparam int DEF_WEIGHT_BITS  = 16;

   localparam int VIDX_BITS   = 5;
   localparam int WFIELD_BITS = 16;
   localparam int VC_BITS     = 6;

   localparam logic [VC_BITS-1:0] VC_RESET = 6'd32;
   localparam logic [VC_BITS-1:0] VC_MIN   = 6'd2;

   typedef struct packed {
      logic [VIDX_BITS-1:0]   row;
      logic [VIDX_BITS-1:0]   col;
      logic [WFIELD_BITS-1:0] weight;
      logic                   last_entry;
   } req_type;

   typedef struct packed {
      logic [VIDX_BITS-1:0]   parent_vertex;
      logic [VIDX_BITS-1:0]   child_vertex;
      logic [WFIELD_BITS-1:0] edge_weight;
      logic                   unreachable;
      logic                   last_edge;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic store_entry;
      logic start_compute;
      logic issue;
      logic emit;
      logic next_round;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_issue;
      logic last_round;
      logic out_free;
   } sts_type;

endpackage

### src/dpm_ctrl.sv
// sequencer for loading, scan passes and edge emission
module dpm_ctrl
   import dpm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_last,
   output logic    req_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               state_in = sts.last_round ? ST_IDLE : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store_entry   = 1'b1;
               cmd.start_compute = req_last;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
            cmd = '0;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit       = 1'b1;
               cmd.next_round = !sts.last_round;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/dpm_datapath.sv
// weight store, distance and parent stores, relax and minimum tracking, result register
module dpm_datapath
   import dpm_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
)(
   input  logic               clock,
   input  logic               reset,
   input  req_type            req_data,
   input  logic               csr_we,
   input  logic [VC_BITS-1:0] csr_wdata,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output rsp_type            rsp_data
);

   localparam int VB    = $clog2(MAX_VERTICES);
   localparam int NB    = $clog2(MAX_VERTICES + 1);
   localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
   localparam int AW    = $clog2(DEPTH);
   localparam int WB    = WEIGHT_BITS;

   logic [WB-1:0] weight_mem [DEPTH];
   logic [WB-1:0] dist_mem   [MAX_VERTICES];
   logic [VB-1:0] par_mem    [MAX_VERTICES];

   logic [VC_BITS-1:0] vc_ff, vc_in;
   logic [VB-1:0]      k_ff, k_in;
   logic [VB-1:0]      round_ff, round_in;
   logic [VB-1:0]      pick_ff, pick_in;
   logic               has_pick_ff, has_pick_in;
   logic               init_ff, init_in;
   logic               vld_d1_ff, vld_d1_in;
   logic [VB-1:0]      k_d1_ff, k_d1_in;
   logic [WB-1:0]      best_ff, best_in;
   logic [VB-1:0]      best_k_ff, best_k_in;
   logic [VB-1:0]      best_p_ff, best_p_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [WB-1:0]      w_rd_ff;
   logic [WB-1:0]      d_rd_ff;
   logic [VB-1:0]      p_rd_ff;

   logic [NB-1:0] n_act;
   logic [VB-1:0] n_m1;
   logic          wr_ok;
   logic [AW-1:0] wr_addr;
   logic [VB-1:0] row_sel;
   logic [AW-1:0] rd_addr;
   logic [WB-1:0] d_eff;
   logic [WB-1:0] new_d;
   logic [VB-1:0] new_p;

   // vertex count clamped to 2 .. MAX_VERTICES
   always_comb begin
      if (vc_ff < VC_MIN) begin
         n_act = NB'(2);
      end else if (32'(vc_ff) > 32'(MAX_VERTICES)) begin
         n_act = NB'(MAX_VERTICES);
      end else begin
         n_act = NB'(vc_ff);
      end
      n_m1 = VB'(n_act - NB'(1));
   end

   assign wr_ok   = (32'(req_data.row) < 32'(MAX_VERTICES)) &&
                    (32'(req_data.col) < 32'(MAX_VERTICES));
   assign wr_addr = AW'(32'(req_data.row) * 32'(MAX_VERTICES) + 32'(req_data.col));

   // row zero on the first pass, else the row of the last chosen vertex
   assign row_sel = init_ff ? '0 : pick_ff;
   assign rd_addr = AW'(32'(row_sel) * 32'(MAX_VERTICES) + 32'(k_ff));

   // relax one vertex, the chosen one drops to zero (in tree)
   always_comb begin
      d_eff = (has_pick_ff && (k_d1_ff == pick_ff)) ? '0 : d_rd_ff;
      if (init_ff) begin
         new_d = w_rd_ff;
         new_p = '0;
      end else if (has_pick_ff && (d_eff != '0) && (d_eff > w_rd_ff)) begin
         new_d = w_rd_ff;
         new_p = pick_ff;
      end else begin
         new_d = d_eff;
         new_p = p_rd_ff;
      end
   end

   always_comb begin
      vc_in        = csr_we ? csr_wdata : vc_ff;
      k_in         = k_ff;
      round_in     = round_ff;
      pick_in      = pick_ff;
      has_pick_in  = has_pick_ff;
      init_in      = init_ff;
      vld_d1_in    = cmd.issue;
      k_d1_in      = k_ff;
      best_in      = best_ff;
      best_k_in    = best_k_ff;
      best_p_in    = best_p_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.issue) begin
         k_in = k_ff + VB'(1);
      end

      // running minimum, strict compare keeps the lowest index on ties
      if (vld_d1_ff && (new_d != '0) && (new_d < best_ff)) begin
         best_in   = new_d;
         best_k_in = k_d1_ff;
         best_p_in = new_p;
         found_in  = 1'b1;
      end

      if (cmd.start_compute) begin
         k_in        = VB'(1);
         round_in    = VB'(1);
         init_in     = 1'b1;
         has_pick_in = 1'b0;
         pick_in     = '0;
      end

      if (cmd.next_round) begin
         k_in        = VB'(1);
         round_in    = round_ff + VB'(1);
         init_in     = 1'b0;
         has_pick_in = found_ff;
         pick_in     = best_k_ff;
      end

      if (cmd.start_compute || cmd.next_round) begin
         best_in   = '1;
         best_k_in = '0;
         best_p_in = '0;
         found_in  = 1'b0;
      end

      if (cmd.emit) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.parent_vertex  = VIDX_BITS'(best_p_ff);
         rsp_data_in.child_vertex   = VIDX_BITS'(best_k_ff);
         rsp_data_in.edge_weight    = WFIELD_BITS'(best_ff);
         rsp_data_in.unreachable    = !found_ff;
         rsp_data_in.last_edge      = (round_ff == n_m1);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff        <= VC_RESET;
         vld_d1_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         init_ff      <= 1'b0;
         has_pick_ff  <= 1'b0;
      end else begin
         vc_ff        <= vc_in;
         vld_d1_ff    <= vld_d1_in;
         rsp_valid_ff <= rsp_valid_in;
         init_ff      <= init_in;
         has_pick_ff  <= has_pick_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      round_ff    <= round_in;
      pick_ff     <= pick_in;
      k_d1_ff     <= k_d1_in;
      best_ff     <= best_in;
      best_k_ff   <= best_k_in;
      best_p_ff   <= best_p_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.store_entry && wr_ok) begin
         weight_mem[wr_addr] <= WB'(req_data.weight);
      end
      if (cmd.issue) begin
         w_rd_ff <= weight_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (vld_d1_ff) begin
         dist_mem[k_d1_ff] <= new_d;
         par_mem[k_d1_ff]  <= new_p;
      end
      if (cmd.issue) begin
         d_rd_ff <= dist_mem[k_ff];
         p_rd_ff <= par_mem[k_ff];
      end
   end

   assign sts.last_issue = (k_ff == n_m1);
   assign sts.last_round = (round_ff == n_m1);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/dense_prim_mst.sv
// top level of the dense prim minimum spanning tree block
// Loads one adjacency-matrix weight per req item (weight_store[row][col]),
// one item per cycle while idle. The item with last_entry set is stored and
// then starts Prim's algorithm from vertex 0 over vertex_count vertices
// (clamped to 2 .. MAX_VERTICES); no req item is taken until all
// vertex_count-1 edge items have been handed to the rsp register. Each round
// is one pass over vertices 1 .. n-1 through the single read port of the
// distance, parent and weight memories, where the pass relaxes against the
// row of the vertex chosen last round and tracks the new minimum at the same
// time. After the reads a round goes through the drain state, then emits its
// edge item as soon as the rsp register is free (rsp_ready or no item held).
// Ties pick the lowest vertex index. A distance of zero means in tree, so
// real weights should be at least 1. A round with no reachable vertex gives
// parent 0, child 0, all-ones weight and unreachable set. Weight entries
// never written read as anything; there is no clearing pass after reset.
// Write vertex_count via csr_we/csr_wdata only while idle; not enforced.
module dense_prim_mst
   import dpm_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
)(
   input  logic               clock,
   input  logic               reset,
   // matrix entry items
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   // tree edge items
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_data,
   // vertex count register
   input  logic               csr_we,
   input  logic [VC_BITS-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // sequencer: idle/load, scan pass, drain, emit
   dpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_entry),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // stores, relax/min pipeline and the rsp register
   dpm_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### src/dpm_checker.sv
// port-level checker for the dense prim mst block and its bind
`include "dense_prim_mst_assert.svh"

module dpm_checker
   import dpm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input req_type            req_data,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input rsp_type            rsp_data
);

   // stalled edge item holds
   `DPM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "rsp item changed while stalled")

   // a last entry starts computing, so no item is taken right after
   `DPM_ASSERT(a_busy_after_last, req_valid && req_ready && req_data.last_entry |=> !req_ready, "req taken right after last entry")

   // unreachable rounds report no edge
   `DPM_ASSERT(a_unreach_zero, rsp_valid && rsp_data.unreachable |-> rsp_data.parent_vertex == '0 && rsp_data.child_vertex == '0, "unreachable item with nonzero vertex")

   // a real edge never has zero weight since zero means in tree
   `DPM_ASSERT(a_edge_nonzero, rsp_valid && !rsp_data.unreachable |-> rsp_data.edge_weight != '0, "reachable edge with zero weight")

   // reset leaves no result pending
   `DPM_ASSERT_ALWAYS(a_reset_clear, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind dense_prim_mst dpm_checker u_dpm_checker (.*);
